// ===== rtl/cascaded_biquad_iir_filter_core_assert.svh =====
// Assertion macros for the cascaded biquad filter core.
// Used by the core RTL; compiled out when SYNTHESIS is defined.
`ifndef CASCADED_BIQUAD_IIR_FILTER_CORE_ASSERT_SVH
`define CASCADED_BIQUAD_IIR_FILTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define CBIQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be true outside reset
`define CBIQ_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `CBIQ_ASSERT(label, clk, rst, !(cond), msg)
`else
`define CBIQ_ASSERT(label, clk, rst, prop, msg)
`define CBIQ_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== rtl/cbiq_pkg.sv =====
// Package for the cascaded biquad filter core: fixed widths, codes, the
// sequencer control word and its microprogram. No dependencies.
`timescale 1ns / 1ps

package cbiq_pkg;

   // fixed field and word widths
   localparam int WORD_BITS     = 32;
   localparam int COEF_BITS     = 24;
   localparam int IDX_BITS      = 5;
   localparam int ACTIVE_BITS   = 3;
   localparam int COEFS_PER_SEC = 5;

   // parameter defaults
   localparam int MAX_SECTIONS_DEF   = 4;
   localparam int SAMPLE_BITS_DEF    = 16;
   localparam int COEF_FRAC_BITS_DEF = 20;

   // saturation limits of an internal word
   localparam logic [WORD_BITS-1:0] WORD_MAX_C = 32'h7fff_ffff;
   localparam logic [WORD_BITS-1:0] WORD_MIN_C = 32'h8000_0000;

   // request kind (tuser)
   localparam logic FUNC_FILTER = 1'b0;
   localparam logic FUNC_COEF   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_OUT
   } state_type;

   // coefficient slot within a section
   typedef enum logic [2:0] {
      SLOT_B0 = 3'd0,
      SLOT_B1 = 3'd1,
      SLOT_B2 = 3'd2,
      SLOT_A1 = 3'd3,
      SLOT_A2 = 3'd4
   } coef_slot_type;

   // multiplier word operand
   typedef enum logic [1:0] {
      MUL_W1,
      MUL_W2,
      MUL_W
   } mul_src_type;

   // accumulator operation on the registered product
   typedef enum logic [2:0] {
      ACC_NOP,
      ACC_LDX_SUB,
      ACC_SUB,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   // sequencer flow control
   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_BR_LAST,
      JMP_GOTO,
      JMP_FINISH
   } jmp_type;

   localparam int UC_STEP_W = 4;
   localparam int UC_DEPTH  = 10;

   // jump targets
   localparam logic [UC_STEP_W-1:0] UC_ENTRY = 4'd0;
   localparam logic [UC_STEP_W-1:0] UC_LOOP  = 4'd2;
   localparam logic [UC_STEP_W-1:0] UC_TAIL  = 4'd8;

   typedef struct packed {
      logic                 rd_en;
      coef_slot_type        slot;
      logic                 mul_en;
      mul_src_type          mul_src;
      acc_op_type           acc_op;
      logic                 rnd_w;
      logic                 rnd_x;
      logic                 dly_wr;
      jmp_type              jmp;
      logic [UC_STEP_W-1:0] target;
   } ucode_word_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] w2;
      logic signed [WORD_BITS-1:0] w1;
   } delay_pair_type;

   // Microprogram. Coefficient read, multiply and accumulate follow in turn,
   // step by step; the head of the next section overlaps the tail of this one.
   localparam ucode_word_type UCODE [UC_DEPTH] = '{
      // 0: head, read a1
      '{1'b1, SLOT_A1, 1'b0, MUL_W1, ACC_NOP,     1'b0, 1'b0, 1'b0, JMP_NEXT,    UC_ENTRY},
      // 1: read a2, a1*w1
      '{1'b1, SLOT_A2, 1'b1, MUL_W1, ACC_NOP,     1'b0, 1'b0, 1'b0, JMP_NEXT,    UC_ENTRY},
      // 2: read b1, a2*w2, acc = x - a1*w1
      '{1'b1, SLOT_B1, 1'b1, MUL_W2, ACC_LDX_SUB, 1'b0, 1'b0, 1'b0, JMP_NEXT,    UC_ENTRY},
      // 3: read b2, b1*w1, acc -= a2*w2
      '{1'b1, SLOT_B2, 1'b1, MUL_W1, ACC_SUB,     1'b0, 1'b0, 1'b0, JMP_NEXT,    UC_ENTRY},
      // 4: read b0, b2*w2, w = round(acc), acc = b1*w1
      '{1'b1, SLOT_B0, 1'b1, MUL_W2, ACC_LOAD,    1'b1, 1'b0, 1'b0, JMP_NEXT,    UC_ENTRY},
      // 5: b0*w, acc += b2*w2, shift delays, next section
      '{1'b0, SLOT_B0, 1'b1, MUL_W,  ACC_ADD,     1'b0, 1'b0, 1'b1, JMP_BR_LAST, UC_TAIL},
      // 6: next head read a1, acc += b0*w
      '{1'b1, SLOT_A1, 1'b0, MUL_W1, ACC_ADD,     1'b0, 1'b0, 1'b0, JMP_NEXT,    UC_ENTRY},
      // 7: read a2, a1*w1, x = round(acc)
      '{1'b1, SLOT_A2, 1'b1, MUL_W1, ACC_NOP,     1'b0, 1'b1, 1'b0, JMP_GOTO,    UC_LOOP},
      // 8: last tail, acc += b0*w
      '{1'b0, SLOT_B0, 1'b0, MUL_W1, ACC_ADD,     1'b0, 1'b0, 1'b0, JMP_NEXT,    UC_ENTRY},
      // 9: x = round(acc), done
      '{1'b0, SLOT_B0, 1'b0, MUL_W1, ACC_NOP,     1'b0, 1'b1, 1'b0, JMP_FINISH,  UC_ENTRY}
   };

endpackage

// ===== rtl/cbiq_ram.sv =====
// Generic RAM for the biquad core: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module cbiq_ram #(
   parameter  int WIDTH  = 24,
   parameter  int DEPTH  = 20,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cascaded_biquad_iir_filter_core.sv =====
// Cascade of up to MAX_SECTIONS direct form II biquads, the coefficient
// RAM and one shared multiply-accumulate run by a microcoded sequencer.
// A coefficient request (tuser 1) gives no response. A sample request
// runs the sequencer through the n active sections, then the output
// state, then the idle state that accepts the next request; the single
// 24x32 multiplier doing five products per section sets the pace. With
// zero sections the sample skips the sequencer and goes straight to the
// output state. The response register lets the next request be taken
// while a result waits. Delay words reset to zero; coefficients must be
// written before use. Depends on cbiq_pkg, cbiq_ram and the assert header.
`timescale 1ns / 1ps
`include "cascaded_biquad_iir_filter_core_assert.svh"

module cascaded_biquad_iir_filter_core #(
   parameter  int MAX_SECTIONS   = cbiq_pkg::MAX_SECTIONS_DEF,
   parameter  int SAMPLE_BITS    = cbiq_pkg::SAMPLE_BITS_DEF,
   parameter  int COEF_FRAC_BITS = cbiq_pkg::COEF_FRAC_BITS_DEF,
   localparam int REQ_DATA_W     =
      ((SAMPLE_BITS + cbiq_pkg::IDX_BITS + cbiq_pkg::COEF_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // sample_in, coef_index, coef_value, zero pad
   input  logic [REQ_DATA_W-1:0]           req_tdata,
   // func
   input  logic                            req_tuser,
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // sample_out, zero pad
   output logic [RSP_DATA_W-1:0]           rsp_tdata,
   // configuration: active_sections
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cbiq_pkg::ACTIVE_BITS-1:0] csr_data
);

   localparam int WORD_W     = cbiq_pkg::WORD_BITS;
   localparam int COEF_W     = cbiq_pkg::COEF_BITS;
   localparam int IDX_W      = cbiq_pkg::IDX_BITS;
   localparam int COEF_DEPTH = cbiq_pkg::COEFS_PER_SEC * MAX_SECTIONS;
   localparam int CADDR_W    = $clog2(COEF_DEPTH);
   localparam int SEC_CNT_W  = $clog2(MAX_SECTIONS + 1);
   localparam int SEC_IDX_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int SEC_CMP_W  = SEC_CNT_W + 1;
   localparam int PROD_W     = COEF_W + WORD_W;
   localparam int XF_W       = WORD_W + COEF_FRAC_BITS;
   localparam int ACC_W      = ((XF_W > PROD_W) ? XF_W : PROD_W) + 2;
   localparam int RND_W      = ACC_W + 1 - COEF_FRAC_BITS;
   localparam int IN_W       = SAMPLE_BITS + WORD_W + 2;
   localparam int OUT_W      = WORD_W + SAMPLE_BITS + 2;
   localparam int IO_SHIFT   = COEF_FRAC_BITS - (SAMPLE_BITS - 1);
   localparam int WIDE_W     = 8;

   localparam logic [ACC_W:0] RND_HALF = (ACC_W + 1)'(1) << (COEF_FRAC_BITS - 1);
   localparam logic [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

   // request fields
   logic [SAMPLE_BITS-1:0] req_sample;
   logic [IDX_W-1:0]       req_idx;
   logic [COEF_W-1:0]      req_coef;
   assign req_sample = req_tdata[SAMPLE_BITS-1:0];
   assign req_idx    = req_tdata[SAMPLE_BITS+IDX_W-1:SAMPLE_BITS];
   assign req_coef   = req_tdata[SAMPLE_BITS+IDX_W+COEF_W-1:SAMPLE_BITS+IDX_W];

   // registers
   cbiq_pkg::state_type          state_ff, state_in;
   logic [cbiq_pkg::UC_STEP_W-1:0] pc_ff, pc_in;
   logic [SEC_CNT_W-1:0]         sec_ff, sec_in;
   logic [CADDR_W-1:0]           coef_base_ff, coef_base_in;
   logic [cbiq_pkg::ACTIVE_BITS-1:0] active_ff, active_in;
   logic                         pass_ff, pass_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]       rsp_data_ff, rsp_data_in;
   logic [SAMPLE_BITS-1:0]       sample_ff, sample_in;
   logic signed [WORD_W-1:0]     x_ff, x_in;
   logic signed [WORD_W-1:0]     w_ff, w_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   cbiq_pkg::delay_pair_type     delay_ff [MAX_SECTIONS];
   cbiq_pkg::delay_pair_type     delay_in;

   // control
   cbiq_pkg::ucode_word_type     ctl;
   logic                         req_ready;
   logic                         start;
   logic                         rsp_load;
   logic                         coef_we;
   logic                         coef_rd_en;
   logic                         idx_ok;
   logic                         last_sec;
   logic [SEC_CNT_W-1:0]         num_sec;
   logic [WIDE_W-1:0]            idx_wide;
   logic [CADDR_W-1:0]           coef_raddr;
   logic [COEF_W-1:0]            coef_rdata;
   logic [SEC_IDX_W-1:0]         sec_idx;
   cbiq_pkg::delay_pair_type     delay_rd;

   // datapath intermediates
   logic signed [WORD_W-1:0]     mul_op;
   logic signed [ACC_W-1:0]      acc_x;
   logic signed [ACC_W-1:0]      acc_p;
   logic signed [ACC_W:0]        rnd_sum;
   logic [RND_W-1:0]             rnd_q;
   logic [RND_W-WORD_W:0]        rnd_hi;
   logic [WORD_W-1:0]            rnd_word;
   logic signed [IN_W-1:0]       in_ext;
   logic signed [IN_W-1:0]       in_q;
   logic [IN_W-WORD_W:0]         in_hi;
   logic [WORD_W-1:0]            in_word;
   logic signed [OUT_W-1:0]      out_ext;
   logic signed [OUT_W-1:0]      out_q;
   logic [OUT_W-SAMPLE_BITS:0]   out_hi;
   logic [SAMPLE_BITS-1:0]       out_smp;

   // configuration port: always ready
   assign csr_ready = 1'b1;
   assign active_in = csr_valid ? csr_data : active_ff;

   // sections in use, clipped to the build size
   always_comb begin
      if (WIDE_W'(active_ff) > WIDE_W'(MAX_SECTIONS)) begin
         num_sec = SEC_CNT_W'(MAX_SECTIONS);
      end else begin
         num_sec = SEC_CNT_W'(active_ff);
      end
   end

   assign last_sec = (SEC_CMP_W'(sec_ff) + SEC_CMP_W'(1)) == SEC_CMP_W'(num_sec);
   assign idx_wide = WIDE_W'(req_idx);
   assign idx_ok   = idx_wide < WIDE_W'(COEF_DEPTH);

   // current control word
   assign ctl = (state_ff == cbiq_pkg::ST_RUN) ? cbiq_pkg::UCODE[pc_ff] : '0;

   // sequencer: next state and handshakes
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      sec_in       = sec_ff;
      coef_base_in = coef_base_ff;
      pass_in      = pass_ff;
      req_ready    = 1'b0;
      start        = 1'b0;
      rsp_load     = 1'b0;
      coef_we      = 1'b0;
      unique case (state_ff)
         cbiq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == cbiq_pkg::FUNC_COEF) begin
                  coef_we = idx_ok;
               end else begin
                  sec_in       = '0;
                  coef_base_in = '0;
                  pc_in        = cbiq_pkg::UC_ENTRY;
                  if (num_sec == '0) begin
                     pass_in  = 1'b1;
                     state_in = cbiq_pkg::ST_OUT;
                  end else begin
                     pass_in  = 1'b0;
                     start    = 1'b1;
                     state_in = cbiq_pkg::ST_RUN;
                  end
               end
            end
         end
         cbiq_pkg::ST_RUN: begin
            pc_in = pc_ff + cbiq_pkg::UC_STEP_W'(1);
            if (ctl.dly_wr) begin
               sec_in       = sec_ff + SEC_CNT_W'(1);
               coef_base_in = coef_base_ff + CADDR_W'(cbiq_pkg::COEFS_PER_SEC);
            end
            unique case (ctl.jmp)
               cbiq_pkg::JMP_NEXT: begin
               end
               cbiq_pkg::JMP_BR_LAST: begin
                  if (last_sec) begin
                     pc_in = ctl.target;
                  end
               end
               cbiq_pkg::JMP_GOTO: begin
                  pc_in = ctl.target;
               end
               cbiq_pkg::JMP_FINISH: begin
                  state_in = cbiq_pkg::ST_OUT;
               end
               default: begin
               end
            endcase
         end
         cbiq_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = cbiq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cbiq_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_tready = req_ready;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbiq_pkg::ST_IDLE;
         pc_ff        <= cbiq_pkg::UC_ENTRY;
         sec_ff       <= '0;
         coef_base_ff <= '0;
         active_ff    <= '0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         sec_ff       <= sec_in;
         coef_base_ff <= coef_base_in;
         active_ff    <= active_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // coefficient store
   assign coef_rd_en = ctl.rd_en;
   assign coef_raddr = coef_base_ff + CADDR_W'(ctl.slot);

   cbiq_ram #(
      .WIDTH (COEF_W),
      .DEPTH (COEF_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (idx_wide[CADDR_W-1:0]),
      .wr_data (req_coef),
      .rd_en   (coef_rd_en),
      .rd_addr (coef_raddr),
      .rd_data (coef_rdata)
   );

   // delay words of the current section
   assign sec_idx  = sec_ff[SEC_IDX_W-1:0];
   assign delay_rd = delay_ff[sec_idx];
   assign delay_in = '{w2: delay_rd.w1, w1: w_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SECTIONS; i++) begin
            delay_ff[i] <= '0;
         end
      end else if (ctl.dly_wr) begin
         delay_ff[sec_idx] <= delay_in;
      end
   end

   // input sample to internal word
   assign in_ext = IN_W'($signed(req_sample));
   generate
      if (IO_SHIFT >= 0) begin : g_in_up
         assign in_q = in_ext <<< IO_SHIFT;
      end else begin : g_in_down
         localparam logic [IN_W-1:0] IN_HALF = IN_W'(1) << (-IO_SHIFT - 1);
         assign in_q = (in_ext + $signed(IN_HALF)) >>> (-IO_SHIFT);
      end
   endgenerate

   assign in_hi = in_q[IN_W-1:WORD_W-1];
   always_comb begin
      if ((&in_hi) || !(|in_hi)) begin
         in_word = in_q[WORD_W-1:0];
      end else if (in_q[IN_W-1]) begin
         in_word = cbiq_pkg::WORD_MIN_C;
      end else begin
         in_word = cbiq_pkg::WORD_MAX_C;
      end
   end

   // shared multiplier, product registered
   always_comb begin
      case (ctl.mul_src)
         cbiq_pkg::MUL_W1: mul_op = delay_rd.w1;
         cbiq_pkg::MUL_W2: mul_op = delay_rd.w2;
         cbiq_pkg::MUL_W:  mul_op = w_ff;
         default:          mul_op = w_ff;
      endcase
   end
   assign prod_in = ctl.mul_en ? ($signed(coef_rdata) * mul_op) : prod_ff;

   // accumulator
   assign acc_x = {{(ACC_W - XF_W){x_ff[WORD_W-1]}}, x_ff, {COEF_FRAC_BITS{1'b0}}};
   assign acc_p = {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   always_comb begin
      case (ctl.acc_op)
         cbiq_pkg::ACC_LDX_SUB: acc_in = acc_x - acc_p;
         cbiq_pkg::ACC_SUB:     acc_in = acc_ff - acc_p;
         cbiq_pkg::ACC_LOAD:    acc_in = acc_p;
         cbiq_pkg::ACC_ADD:     acc_in = acc_ff + acc_p;
         default:               acc_in = acc_ff;
      endcase
   end

   // round half up, drop fraction bits, saturate to a word
   assign rnd_sum = {acc_ff[ACC_W-1], acc_ff} + $signed(RND_HALF);
   assign rnd_q   = rnd_sum[ACC_W:COEF_FRAC_BITS];
   assign rnd_hi  = rnd_q[RND_W-1:WORD_W-1];
   always_comb begin
      if ((&rnd_hi) || !(|rnd_hi)) begin
         rnd_word = rnd_q[WORD_W-1:0];
      end else if (rnd_q[RND_W-1]) begin
         rnd_word = cbiq_pkg::WORD_MIN_C;
      end else begin
         rnd_word = cbiq_pkg::WORD_MAX_C;
      end
   end

   assign w_in = ctl.rnd_w ? rnd_word : w_ff;
   assign x_in = start ? in_word : (ctl.rnd_x ? rnd_word : x_ff);

   // internal word back to sample
   assign out_ext = OUT_W'(x_ff);
   generate
      if (IO_SHIFT > 0) begin : g_out_down
         localparam logic [OUT_W-1:0] OUT_HALF = OUT_W'(1) << (IO_SHIFT - 1);
         assign out_q = (out_ext + $signed(OUT_HALF)) >>> IO_SHIFT;
      end else begin : g_out_up
         assign out_q = out_ext <<< (-IO_SHIFT);
      end
   endgenerate

   assign out_hi = out_q[OUT_W-1:SAMPLE_BITS-1];
   always_comb begin
      if ((&out_hi) || !(|out_hi)) begin
         out_smp = out_q[SAMPLE_BITS-1:0];
      end else if (out_q[OUT_W-1]) begin
         out_smp = SMP_MIN;
      end else begin
         out_smp = SMP_MAX;
      end
   end

   // pass-through sample and response register
   assign sample_in    = (start || (req_ready && req_tvalid)) ? req_sample : sample_ff;
   assign rsp_data_in  = rsp_load ? (pass_ff ? sample_ff : out_smp) : rsp_data_ff;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   // payload registers
   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      x_ff        <= x_in;
      w_ff        <= w_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

   // checks
   `CBIQ_ASSERT(a_sec_in_range, clock, reset, (state_ff == cbiq_pkg::ST_RUN && ctl.dly_wr) |-> (sec_ff < num_sec), "section counter ran past the active sections")
   `CBIQ_ASSERT(a_out_waits, clock, reset, (state_ff == cbiq_pkg::ST_OUT && rsp_valid_ff && !rsp_tready) |=> (state_ff == cbiq_pkg::ST_OUT && rsp_valid_ff), "result overwrote a waiting response")
   `CBIQ_ASSERT_NEVER(a_coef_collide, clock, reset, coef_we && coef_rd_en, "coefficient write during a sequencer read")
   `CBIQ_ASSERT(a_filter_starts, clock, reset, (req_tvalid && req_ready && req_tuser == cbiq_pkg::FUNC_FILTER) |=> (state_ff != cbiq_pkg::ST_IDLE), "sample request did not start a run")

endmodule

// ===== tb/biquad_cascade_checker.sv =====
// Checker for the cascaded biquad filter core: watches the request, response
// and csr channels, predicts each filtered sample and compares responses.
// Depends on cbiq_pkg.
`timescale 1ns / 1ps

module biquad_cascade_checker #(
   parameter int REQ_W = 48,
   parameter int RSP_W = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // sample_in, coef_index, coef_value, zero pad
   input  logic [REQ_W-1:0]                 req_tdata,
   // func
   input  logic                             req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // sample_out
   input  logic [RSP_W-1:0]                 rsp_tdata,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [cbiq_pkg::ACTIVE_BITS-1:0] csr_data,
   output int                               failures,
   output int                               pending
);

   localparam int SECTIONS = cbiq_pkg::MAX_SECTIONS_DEF;
   localparam int SAMPLE_W = cbiq_pkg::SAMPLE_BITS_DEF;
   localparam int FRAC     = cbiq_pkg::COEF_FRAC_BITS_DEF;
   localparam int WORD_W   = cbiq_pkg::WORD_BITS;
   localparam int COEF_W   = cbiq_pkg::COEF_BITS;
   localparam int IDX_W    = cbiq_pkg::IDX_BITS;
   localparam int PER_SEC  = cbiq_pkg::COEFS_PER_SEC;
   localparam int ACT_W    = cbiq_pkg::ACTIVE_BITS;
   localparam int SHIFT    = FRAC - (SAMPLE_W - 1);
   localparam int IDX_LSB  = SAMPLE_W;
   localparam int VAL_LSB  = SAMPLE_W + IDX_W;
   localparam int NUM_COEF = PER_SEC * SECTIONS;

   localparam longint WORD_HI = (64'sd1 <<< (WORD_W - 1)) - 64'sd1;
   localparam longint WORD_LO = -(64'sd1 <<< (WORD_W - 1));
   localparam longint SAMP_HI = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
   localparam longint SAMP_LO = -(64'sd1 <<< (SAMPLE_W - 1));

   // shadow of the filter state
   logic signed [COEF_W-1:0] coef_bank [NUM_COEF];
   logic signed [WORD_W-1:0] delay_w1 [SECTIONS];
   logic signed [WORD_W-1:0] delay_w2 [SECTIONS];
   logic [ACT_W-1:0]         sections_set;

   logic signed [SAMPLE_W-1:0]  expected_samples [$];
   int                          fail_count = 0;

   // drop the extra fraction bits (add half, floor) and clamp to a word
   function automatic logic signed [WORD_W-1:0] round_word(longint acc);
      longint r;
      r = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
      if (r > WORD_HI)
         r = WORD_HI;
      else if (r < WORD_LO)
         r = WORD_LO;
      return r[WORD_W-1:0];
   endfunction

   // run one sample through the active sections, updating the delay words
   function automatic logic signed [SAMPLE_W-1:0] filter_sample(
      logic signed [SAMPLE_W-1:0] s
   );
      longint                   x, acc, y, w1, w2;
      logic signed [WORD_W-1:0] w;
      int                       n, base;
      n = (sections_set > SECTIONS) ? SECTIONS : int'(sections_set);
      if (n == 0)
         return s;
      x = longint'(s) <<< SHIFT;
      for (int k = 0; k < n; k++) begin
         base = PER_SEC * k;
         w1   = longint'(delay_w1[k]);
         w2   = longint'(delay_w2[k]);
         acc  = (x <<< FRAC) - longint'(coef_bank[base + cbiq_pkg::SLOT_A1]) * w1
                - longint'(coef_bank[base + cbiq_pkg::SLOT_A2]) * w2;
         w    = round_word(acc);
         acc  = longint'(coef_bank[base + cbiq_pkg::SLOT_B0]) * longint'(w)
                + longint'(coef_bank[base + cbiq_pkg::SLOT_B1]) * w1
                + longint'(coef_bank[base + cbiq_pkg::SLOT_B2]) * w2;
         x    = longint'(round_word(acc));
         delay_w2[k] = delay_w1[k];
         delay_w1[k] = w;
      end
      y = (x + (64'sd1 <<< (SHIFT - 1))) >>> SHIFT;
      if (y > SAMP_HI)
         y = SAMP_HI;
      else if (y < SAMP_LO)
         y = SAMP_LO;
      return y[SAMPLE_W-1:0];
   endfunction

   // monitor: config, then responses against older requests, then new requests
   always @(posedge clock) begin : monitor
      logic signed [SAMPLE_W-1:0] got, want;
      logic [IDX_W-1:0]           idx;
      if (reset) begin
         foreach (coef_bank[i])
            coef_bank[i] = '0;
         foreach (delay_w1[i]) begin
            delay_w1[i] = '0;
            delay_w2[i] = '0;
         end
         sections_set = '0;
         expected_samples.delete();
      end else begin
         if (csr_valid && csr_ready)
            sections_set = csr_data;

         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[SAMPLE_W-1:0];
            if (expected_samples.size() == 0) begin
               $display("%0t: sample_out expected none, actual %0d", $time, got);
               fail_count++;
            end else begin
               want = expected_samples.pop_front();
               if (got !== want) begin
                  $display("%0t: sample_out expected %0d, actual %0d",
                           $time, want, got);
                  fail_count++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            if (req_tuser == cbiq_pkg::FUNC_COEF) begin
               idx = req_tdata[IDX_LSB +: IDX_W];
               if (idx < NUM_COEF)
                  coef_bank[idx] = req_tdata[VAL_LSB +: COEF_W];
            end else begin
               expected_samples.push_back(filter_sample(req_tdata[SAMPLE_W-1:0]));
            end
         end
      end
      pending  <= expected_samples.size();
      failures <= fail_count;
   end

endmodule

// ===== tb/cascaded_biquad_iir_filter_core_test.sv =====
// Top of the cascaded biquad filter core test: clock, reset, request and
// csr stimulus, response stalls and the verdict. Depends on cbiq_pkg, the
// core and biquad_cascade_checker.
`timescale 1ns / 1ps

module cascaded_biquad_iir_filter_core_test;

   localparam int CLK_HALF    = 5;
   localparam int SAMPLE_W    = cbiq_pkg::SAMPLE_BITS_DEF;
   localparam int IDX_W       = cbiq_pkg::IDX_BITS;
   localparam int COEF_W      = cbiq_pkg::COEF_BITS;
   localparam int ACT_W       = cbiq_pkg::ACTIVE_BITS;
   localparam int PER_SEC     = cbiq_pkg::COEFS_PER_SEC;
   localparam int SECTIONS    = cbiq_pkg::MAX_SECTIONS_DEF;
   localparam int PAYLOAD_W   = SAMPLE_W + IDX_W + COEF_W;
   localparam int REQ_W       = ((PAYLOAD_W + 7) / 8) * 8;
   localparam int RSP_W       = ((SAMPLE_W + 7) / 8) * 8;
   localparam int NUM_COEF    = PER_SEC * SECTIONS;
   localparam int ITEMS       = 1650;
   localparam int IDLE_WAIT   = 40;
   localparam int DRAIN_WAIT  = 40;
   localparam int QUIET_LIMIT = 4000;
   localparam int Q20_ONE     = 1 << cbiq_pkg::COEF_FRAC_BITS_DEF;

   localparam logic signed [COEF_W-1:0]   COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0]   COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] SAMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata  = '0;
   logic                   req_tuser  = cbiq_pkg::FUNC_FILTER;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [ACT_W-1:0]       csr_data   = '0;

   int failures;
   int pending;
   int quiet_cycles = 0;
   int burst_left   = 0;
   int items_sent   = 0;
   int rx_left      = 0;
   logic [1:0] rx_mode = 2'd0;

   always #CLK_HALF clock = ~clock;

   cascaded_biquad_iir_filter_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   biquad_cascade_checker #(
      .REQ_W (REQ_W),
      .RSP_W (RSP_W)
   ) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .failures   (failures),
      .pending    (pending)
   );

   // receiver: ready pattern changes mode after a run of random length
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= 2'($urandom_range(0, 3));
         rx_left <= $urandom_range(20, 300);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_mode)
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= 1'($urandom_range(0, 1));
         2'd2: rsp_tready <= ($urandom_range(0, 7) == 0);
         default: rsp_tready <= (rx_left % 4 != 0);
      endcase
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   // one request; the sender may pause between bursts of random length
   task automatic send_request(logic func, logic signed [SAMPLE_W-1:0] s,
                               logic [IDX_W-1:0] idx,
                               logic signed [COEF_W-1:0] val);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tuser  <= func;
      req_tdata  <= {{(REQ_W - PAYLOAD_W){1'b0}}, val, idx, s};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!(func == cbiq_pkg::FUNC_COEF && idx >= NUM_COEF))
         items_sent++;
   endtask

   task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
      send_request(cbiq_pkg::FUNC_FILTER, s, IDX_W'($urandom()), COEF_W'($urandom()));
   endtask

   task automatic send_coef(int idx, logic signed [COEF_W-1:0] val);
      send_request(cbiq_pkg::FUNC_COEF, SAMPLE_W'($urandom()), IDX_W'(idx), val);
   endtask

   // section count only changes once the core has drained
   task automatic write_sections(logic [ACT_W-1:0] n);
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
      csr_data  <= n;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // full coefficient set: stable sections, or raw words when wild
   task automatic load_coef_set(bit wild);
      int a1, a2, lim;
      for (int k = 0; k < SECTIONS; k++) begin
         a2  = int'($urandom_range(0, 1900000)) - 950000;
         lim = ((Q20_ONE + a2) / 100) * 95;
         a1  = int'($urandom_range(0, 2 * lim)) - lim;
         for (int slot = 0; slot < PER_SEC; slot++) begin
            if (wild)
               send_coef(PER_SEC * k + slot, COEF_W'($urandom()));
            else if (slot == cbiq_pkg::SLOT_A1)
               send_coef(PER_SEC * k + slot, COEF_W'(a1));
            else if (slot == cbiq_pkg::SLOT_A2)
               send_coef(PER_SEC * k + slot, COEF_W'(a2));
            else
               send_coef(PER_SEC * k + slot,
                         COEF_W'(int'($urandom_range(0, Q20_ONE)) - Q20_ONE / 2));
         end
      end
   endtask

   initial begin : stimulus
      logic [ACT_W-1:0]         order [8];
      logic [ACT_W-1:0]         n;
      int                       phase, phase_len, amp_bits, r;
      logic signed [COEF_W-1:0] cval;
      order = '{3'd4, 3'd0, 3'd1, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: pass-through at zero sections after reset
      send_sample(SAMP_MIN);
      send_sample(SAMP_MAX);
      // fill the whole coefficient store, then extreme words in the last section
      load_coef_set(1'b0);
      send_coef(PER_SEC * 3 + cbiq_pkg::SLOT_B0, COEF_MAX);
      send_coef(PER_SEC * 3 + cbiq_pkg::SLOT_A2, COEF_MIN);
      // writes past the store are dropped
      send_coef(NUM_COEF, COEF_MAX);
      send_coef((1 << IDX_W) - 1, COEF_MIN);
      // full cascade with saturating last section
      write_sections(3'd4);
      send_sample(SAMP_MIN);
      send_sample(SAMP_MAX);

      // random phases: section count, coefficient reload, sample stream
      phase = 0;
      while (items_sent < ITEMS) begin
         n = (phase < 8) ? order[phase] : ACT_W'($urandom_range(0, 7));
         write_sections(n);
         if ($urandom_range(0, 4) != 0)
            load_coef_set($urandom_range(0, 5) == 0);
         phase_len = $urandom_range(60, 200);
         case ($urandom_range(0, 3))
            0: amp_bits = 4;
            1: amp_bits = 8;
            2: amp_bits = 12;
            default: amp_bits = SAMPLE_W;
         endcase
         for (int i = 0; i < phase_len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
               // stray coefficient write, now and then an extreme word
               case ($urandom_range(0, 7))
                  0: cval = COEF_MAX;
                  1: cval = COEF_MIN;
                  default: cval = COEF_W'($urandom());
               endcase
               send_coef($urandom_range(0, (1 << IDX_W) - 1), cval);
            end else if (r < 8) begin
               send_sample(($urandom_range(0, 1) == 0) ? SAMP_MIN : SAMP_MAX);
            end else begin
               send_sample(SAMPLE_W'(int'($urandom()) >>> (32 - amp_bits)));
            end
         end
         phase++;
      end

      // drain and verdict
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
